### rtl/stq_pkg.sv
// Package with widths, codes and item types of the sorted timer queue.
package stq_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int FIRE_LIMIT  = 32;
    localparam int IDX_W       = $clog2(TIMER_COUNT);
    localparam int LINK_W      = $clog2(TIMER_COUNT + 1);
    localparam int FIRE_W      = $clog2(FIRE_LIMIT + 1);
    localparam logic [LINK_W-1:0] NONE = LINK_W'(TIMER_COUNT);
    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

    typedef enum logic [1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_CHECK  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_BAD_NUM = 2'd2,
        ST_BAD_VAL = 2'd3
    } status_t;

    typedef struct packed {
        logic [63:0] now_time;
        logic [31:0] interval_nanoseconds;
        logic [31:0] interval_seconds;
        logic [31:0] value_nanoseconds;
        logic [31:0] value_seconds;
        logic [7:0]  timer_number_in;
        logic [1:0]  func;
    } in_item_t;

    typedef struct packed {
        logic        last;
        logic        resume_now;
        logic [63:0] rearm_delay;
        logic        rearm_valid;
        logic [3:0]  timer_number;
        logic        kind;
        logic [1:0]  status;
    } out_item_t;

endpackage

### rtl/stq_mul.sv
// Shift-and-add multiplier that turns a seconds count into nanoseconds.
module stq_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] seconds,
    output logic        done,
    output logic [63:0] product
);
    import stq_pkg::*;

    logic [30:0] mplr_reg, mplr_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcnd_reg, mcnd_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;

    // One multiplier bit per cycle.
    always_comb begin
        mplr_next = mplr_reg;
        acc_next  = acc_reg;
        mcnd_next = mcnd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            mplr_next = seconds;
            acc_next  = 64'd0;
            mcnd_next = {32'd0, NS_PER_SEC};
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mplr_reg[0]) begin
                acc_next = acc_reg + mcnd_reg;
            end
            mplr_next = mplr_reg >> 1;
            mcnd_next = mcnd_reg << 1;
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30) begin
                busy_next = 1'b0;
            end
        end
    end

    // The product is ready whenever no multiplication is running.
    assign done    = !busy_reg;
    assign product = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        mplr_reg <= mplr_next;
        acc_reg  <= acc_next;
        mcnd_reg <= mcnd_next;
    end
endmodule

### rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue: timer table, list walker and result output.
//
// One input item is worked on at a time and s_tready stays low until all of its
// results are delivered. Create, a delete of a free timer and errors go straight
// to the final result; a delete that frees a timer first unlinks it. A set converts
// both times with one shared 31-step multiplier and then walks the sorted list, one
// entry per cycle. A check unlinks each expired timer and walks the list again for
// each periodic rearm, and at most FIRE_LIMIT notices precede the final result. The
// walk over the linked list, one entry per cycle, sets the insertion time. After
// reset the free chain is built by one pass over all TIMER_COUNT entries before the
// first item.
module sorted_timer_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0 up: func, timer_number_in, value_seconds,
    // value_nanoseconds, interval_seconds, interval_nanoseconds, now_time.
    input  logic [207:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0 up: status, timer_number, rearm_valid, rearm_delay,
    // resume_now.
    output logic [71:0]  m_tdata,
    // Field: kind.
    output logic         m_tuser,
    output logic         m_tlast
);
    import stq_pkg::*;

    typedef enum logic [15:0] {
        S_INIT    = 16'h0001,
        S_IDLE    = 16'h0002,
        S_DECODE  = 16'h0004,
        S_MUL_V   = 16'h0008,
        S_MUL_I   = 16'h0010,
        S_UNLINK  = 16'h0020,
        S_UNLINK2 = 16'h0040,
        S_WALK    = 16'h0080,
        S_LINK    = 16'h0100,
        S_LINK2   = 16'h0200,
        S_CHECK   = 16'h0400,
        S_FIRE    = 16'h0800,
        S_FINAL   = 16'h1000,
        S_FINAL2  = 16'h2000,
        S_OUT     = 16'h4000,
        S_DELFREE = 16'h8000
    } state_t;

    // Timer table.
    logic [LINK_W-1:0] next_mem [TIMER_COUNT];
    logic [LINK_W-1:0] prev_mem [TIMER_COUNT];
    logic [63:0]       dl_mem   [TIMER_COUNT];
    logic [63:0]       per_mem  [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] active_reg, allocated_reg;
    logic [LINK_W-1:0] head_reg, free_reg;

    state_t            state_reg;
    in_item_t          item_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  t_reg;
    logic [LINK_W-1:0] cur_reg, before_reg;
    logic [63:0]       vns_reg, ins_reg, new_dl_reg;
    logic              insert_reg, to_free_reg, from_check_reg;
    logic [FIRE_W-1:0] fire_reg;
    logic [LINK_W-1:0] init_reg;
    logic              mul_start;
    logic [30:0]       mul_sec;
    logic              mul_done;
    logic [63:0]       mul_prod;
    logic              wait_reg;

    stq_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .seconds (mul_sec),
        .done    (mul_done),
        .product (mul_prod)
    );

    // A time field is valid when both parts are non-negative and ns is in range.
    function automatic logic time_ok(input logic [31:0] sec, input logic [31:0] ns);
        time_ok = !sec[31] && !ns[31] && (ns < NS_PER_SEC);
    endfunction

    // Result item with only a status and a timer number filled in.
    function automatic out_item_t early_out(input status_t st, input logic [3:0] num);
        early_out = '0;
        early_out.status = st;
        early_out.timer_number = num;
    endfunction

    // Expiry notice for one timer.
    function automatic out_item_t notice_out(input logic [3:0] num);
        notice_out = '0;
        notice_out.kind = 1'b1;
        notice_out.timer_number = num;
    endfunction

    // Final result: keeps status and number, adds the head information.
    function automatic out_item_t final_out(input out_item_t prev, input logic have_head,
                                            input logic [63:0] dl, input logic [63:0] now);
        final_out = '0;
        final_out.status = prev.status;
        final_out.timer_number = prev.timer_number;
        final_out.last = 1'b1;
        if (have_head) begin
            if (dl > now) begin
                final_out.rearm_valid = 1'b1;
                final_out.rearm_delay = dl - now;
            end else begin
                final_out.resume_now = 1'b1;
            end
        end
    endfunction

    logic [IDX_W-1:0] id_idx;
    logic [IDX_W-1:0] cur_idx, head_idx;
    assign id_idx   = item_reg.timer_number_in[IDX_W-1:0];
    assign cur_idx  = cur_reg[IDX_W-1:0];
    assign head_idx = head_reg[IDX_W-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.resume_now, out_reg.rearm_delay,
                       out_reg.rearm_valid, out_reg.timer_number, out_reg.status};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // The value product is started on decode, the interval product once it is done.
    assign mul_start = ((state_reg == S_DECODE) && (item_reg.func == FUNC_SET) && !wait_reg)
                       || ((state_reg == S_MUL_V) && !wait_reg && mul_done);
    assign mul_sec   = (state_reg == S_MUL_V) ? item_reg.interval_seconds[30:0]
                                              : item_reg.value_seconds[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            head_reg      <= NONE;
            free_reg      <= '0;
            active_reg    <= '0;
            allocated_reg <= '0;
            out_valid_reg <= 1'b0;
            wait_reg      <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                // Build the free chain.
                S_INIT: begin
                    next_mem[init_reg[IDX_W-1:0]] <= init_reg + LINK_W'(1);
                    init_reg <= init_reg + LINK_W'(1);
                    if (init_reg == LINK_W'(TIMER_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        item_reg       <= s_tdata[201:0];
                        fire_reg       <= '0;
                        from_check_reg <= 1'b0;
                        wait_reg       <= 1'b0;
                        state_reg      <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (item_reg.func)
                        FUNC_CREATE: begin
                            if (free_reg == NONE) begin
                                out_reg <= early_out(ST_NO_FREE, 4'd0);
                            end else begin
                                free_reg <= next_mem[free_reg[IDX_W-1:0]];
                                next_mem[free_reg[IDX_W-1:0]] <= NONE;
                                allocated_reg[free_reg[IDX_W-1:0]] <= 1'b1;
                                out_reg <= early_out(ST_OK, 4'(free_reg));
                            end
                            state_reg <= S_FINAL;
                        end
                        FUNC_SET: begin
                            if (item_reg.timer_number_in >= 8'(TIMER_COUNT)
                                || !allocated_reg[id_idx]) begin
                                out_reg <= early_out(ST_BAD_NUM, 4'd0);
                                state_reg <= S_FINAL;
                            end else if (!time_ok(item_reg.value_seconds,
                                                  item_reg.value_nanoseconds)
                                         || !time_ok(item_reg.interval_seconds,
                                                     item_reg.interval_nanoseconds)) begin
                                out_reg <= early_out(ST_BAD_VAL, 4'd0);
                                state_reg <= S_FINAL;
                            end else begin
                                out_reg   <= '0;
                                t_reg     <= id_idx;
                                wait_reg  <= 1'b1;
                                state_reg <= S_MUL_V;
                            end
                        end
                        FUNC_DELETE: begin
                            if (item_reg.timer_number_in >= 8'(TIMER_COUNT)) begin
                                out_reg <= early_out(ST_BAD_NUM, 4'd0);
                                state_reg <= S_FINAL;
                            end else if (allocated_reg[id_idx]) begin
                                out_reg     <= '0;
                                t_reg       <= id_idx;
                                to_free_reg <= 1'b1;
                                insert_reg  <= 1'b0;
                                state_reg   <= S_UNLINK;
                            end else begin
                                out_reg   <= '0;
                                state_reg <= S_FINAL;
                            end
                        end
                        default: begin
                            out_reg <= '0;
                            from_check_reg <= 1'b1;
                            state_reg <= S_CHECK;
                        end
                    endcase
                end
                // Value seconds in progress; then start on the interval.
                S_MUL_V: begin
                    if (wait_reg) begin
                        wait_reg <= 1'b0;
                    end else if (mul_done) begin
                        vns_reg <= mul_prod + {32'd0, item_reg.value_nanoseconds};
                        state_reg <= S_MUL_I;
                        wait_reg <= 1'b1;
                    end
                end
                S_MUL_I: begin
                    if (wait_reg) begin
                        wait_reg <= 1'b0;
                    end else if (mul_done) begin
                        ins_reg <= mul_prod + {32'd0, item_reg.interval_nanoseconds};
                        to_free_reg <= 1'b0;
                        insert_reg <= 1'b1;
                        state_reg <= S_UNLINK;
                    end
                end
                // Remove timer t_reg from the active list if it is there.
                S_UNLINK: begin
                    if (active_reg[t_reg]) begin
                        if (prev_mem[t_reg] == NONE) begin
                            head_reg <= next_mem[t_reg];
                        end else begin
                            next_mem[prev_mem[t_reg][IDX_W-1:0]] <= next_mem[t_reg];
                        end
                        if (next_mem[t_reg] != NONE) begin
                            prev_mem[next_mem[t_reg][IDX_W-1:0]] <= prev_mem[t_reg];
                        end
                        active_reg[t_reg] <= 1'b0;
                    end
                    state_reg <= S_UNLINK2;
                end
                // Decide what follows the removal once the head is settled.
                S_UNLINK2: begin
                    if (to_free_reg) begin
                        state_reg <= S_DELFREE;
                    end else if (from_check_reg) begin
                        if (per_mem[t_reg] != 64'd0) begin
                            new_dl_reg <= dl_mem[t_reg] + per_mem[t_reg];
                            cur_reg    <= head_reg;
                            before_reg <= NONE;
                            state_reg  <= S_WALK;
                        end else begin
                            state_reg <= S_FIRE;
                        end
                    end else if (insert_reg && (vns_reg != 64'd0 || ins_reg != 64'd0)) begin
                        new_dl_reg <= vns_reg + item_reg.now_time;
                        per_mem[t_reg] <= ins_reg;
                        cur_reg    <= head_reg;
                        before_reg <= NONE;
                        state_reg  <= S_WALK;
                    end else begin
                        state_reg <= S_FINAL;
                    end
                end
                S_DELFREE: begin
                    next_mem[t_reg] <= free_reg;
                    free_reg <= LINK_W'(t_reg);
                    allocated_reg[t_reg] <= 1'b0;
                    state_reg <= S_FINAL;
                end
                // Step past every entry whose deadline is not above the new one.
                S_WALK: begin
                    if (cur_reg != NONE && new_dl_reg >= dl_mem[cur_idx]) begin
                        before_reg <= cur_reg;
                        cur_reg    <= next_mem[cur_idx];
                    end else begin
                        state_reg <= S_LINK;
                    end
                end
                S_LINK: begin
                    dl_mem[t_reg]   <= new_dl_reg;
                    next_mem[t_reg] <= cur_reg;
                    prev_mem[t_reg] <= before_reg;
                    active_reg[t_reg] <= 1'b1;
                    state_reg <= S_LINK2;
                end
                // Point the neighbors at the inserted timer.
                S_LINK2: begin
                    if (before_reg == NONE) begin
                        head_reg <= LINK_W'(t_reg);
                    end else begin
                        next_mem[before_reg[IDX_W-1:0]] <= LINK_W'(t_reg);
                    end
                    if (cur_reg != NONE) begin
                        prev_mem[cur_idx] <= LINK_W'(t_reg);
                    end
                    state_reg <= from_check_reg ? S_FIRE : S_FINAL;
                end
                // Decide whether the head has expired.
                S_CHECK: begin
                    if (!out_valid_reg) begin
                        if (fire_reg != FIRE_W'(FIRE_LIMIT) && head_reg != NONE
                            && dl_mem[head_idx] < item_reg.now_time) begin
                            t_reg       <= head_idx;
                            to_free_reg <= 1'b0;
                            insert_reg  <= 1'b0;
                            state_reg   <= S_UNLINK;
                        end else begin
                            out_reg   <= '0;
                            state_reg <= S_FINAL;
                        end
                    end
                end
                // Emit the notice for t_reg.
                S_FIRE: begin
                    if (!out_valid_reg) begin
                        out_reg <= notice_out(4'(t_reg));
                        out_valid_reg <= 1'b1;
                        fire_reg <= fire_reg + FIRE_W'(1);
                        state_reg <= S_CHECK;
                    end
                end
                // Final result with the head information.
                S_FINAL: begin
                    state_reg <= S_FINAL2;
                end
                S_FINAL2: begin
                    if (!out_valid_reg) begin
                        out_reg <= final_out(out_reg, head_reg != NONE, dl_mem[head_idx],
                                             item_reg.now_time);
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_valid_reg && m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
